// ===== sv/cep_pkg.sv =====
`default_nettype none
package cep_pkg;

    localparam int DW  = 48;
    localparam int BW  = 192;
    localparam int RW  = 96;
    // |v| * time_step stays below 2^68
    localparam int MOVE_BITS = 68;
    localparam int RECIP_SHIFT = 98;

    localparam logic [7:0] MUL_CNT  = 8'd48;
    localparam logic [7:0] DIV_CNT  = 8'd192;
    localparam logic [7:0] MOVE_CNT = 8'(MOVE_BITS);

    localparam logic [BW-1:0] GIGA = BW'(1000000000);
    localparam logic [BW-1:0] KILO = BW'(1000);
    // ceil(2^98 / 1e9), exact floor quotient for dividends below 2^68
    localparam logic [BW-1:0] RECIP_GIGA = ((BW'(1) << RECIP_SHIFT) / GIGA) + BW'(1);

    localparam logic [1:0] REG_ACCEL   = 2'd0;
    localparam logic [1:0] REG_STEP    = 2'd1;
    localparam logic [1:0] REG_START_X = 2'd2;

    localparam logic signed [31:0] ACCEL_RST   = 32'sd3183;
    localparam logic [19:0]        STEP_RST    = 20'd10000;
    localparam logic signed [47:0] START_X_RST = -48'sd100000000000;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic {MD_MUL, MD_DIV} t_md_op;

    typedef struct packed {
        logic       start;
        t_md_op     op;
        logic [7:0] cnt;
    } t_md_ctl;

    typedef struct packed {
        logic signed [31:0] accel_coeff;
        logic [19:0]        time_step;
        logic signed [47:0] start_x;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_R2, S_R3, S_C1, S_C2, S_C3, S_C4,
        S_NX, S_DX, S_NY, S_DY, S_MX, S_DMX, S_MY, S_DMY, S_CORD, S_OUT
    } t_state;

    typedef enum logic [2:0] {C_IDLE, C_NORM, C_ROT, C_FIN, C_QUAD} t_cst;

    function automatic logic [47:0] mag48(input logic [47:0] v);
        return v[47] ? 48'd0 - v : v;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    function automatic logic [47:0] sat48(input logic [49:0] v);
        if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
            return v[47:0];
        end
        return v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic [17:0] cordic_angle(input logic [3:0] i);
        case (i)
            4'd0:    return 18'd131072;
            4'd1:    return 18'd77376;
            4'd2:    return 18'd40884;
            4'd3:    return 18'd20753;
            4'd4:    return 18'd10417;
            4'd5:    return 18'd5213;
            4'd6:    return 18'd2607;
            4'd7:    return 18'd1304;
            4'd8:    return 18'd652;
            4'd9:    return 18'd326;
            4'd10:   return 18'd163;
            4'd11:   return 18'd81;
            4'd12:   return 18'd41;
            4'd13:   return 18'd20;
            4'd14:   return 18'd10;
            4'd15:   return 18'd5;
            default: return 18'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== sv/cep_regs.sv =====
`default_nettype none
module cep_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    output cep_pkg::t_cfg    o_cfg
);
    import cep_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_coeff <= ACCEL_RST;
            r_cfg.time_step   <= STEP_RST;
            r_cfg.start_x     <= START_X_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_ACCEL:   r_cfg.accel_coeff <= pwdata[31:0];
                REG_STEP:    r_cfg.time_step   <= pwdata[19:0];
                REG_START_X: r_cfg.start_x     <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_ACCEL:   prdata = {32'd0, r_cfg.accel_coeff};
            REG_STEP:    prdata = {44'd0, r_cfg.time_step};
            REG_START_X: prdata = {16'd0, r_cfg.start_x};
            default:     prdata = 64'd0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

// ===== sv/cep_muldiv.sv =====
`default_nettype none
module cep_muldiv (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  cep_pkg::t_md_ctl            i_ctl,
    input  wire logic [cep_pkg::BW-1:0] i_a,
    input  wire logic [cep_pkg::BW-1:0] i_b,
    output logic [cep_pkg::BW-1:0]      o_res,
    output logic                        o_done
);
    import cep_pkg::*;

    logic          r_busy;
    logic          r_done;
    t_md_op        r_op;
    logic [7:0]    r_cnt;
    logic [BW-1:0] r_acc;
    logic [BW-1:0] r_x;
    logic [BW-1:0] r_b;

    logic [BW-1:0] w_trial;
    logic [BW:0]   w_sum;
    logic          w_sub;

    // one adder: acc + multiplicand, or trial remainder - divisor
    always_comb begin
        w_trial = {r_acc[BW-2:0], r_x[BW-1]};
        w_sub   = (r_op == MD_DIV);
        w_sum   = {1'b0, (w_sub ? w_trial : r_acc)} + {1'b0, (w_sub ? ~r_b : r_x)}
                + {{BW{1'b0}}, w_sub};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 8'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_cnt <= i_ctl.cnt;
            r_acc <= '0;
            r_x   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 8'd1;
            if (r_op == MD_MUL) begin
                if (r_b[0]) begin
                    r_acc <= w_sum[BW-1:0];
                end
                r_x <= {r_x[BW-2:0], 1'b0};
                r_b <= {1'b0, r_b[BW-1:1]};
            end else begin
                r_acc <= w_sum[BW] ? w_sum[BW-1:0] : w_trial;
                r_x   <= {r_x[BW-2:0], w_sum[BW]};
            end
        end
    end

    assign o_res  = (r_op == MD_DIV) ? r_x : r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== sv/cep_isqrt.sv =====
`default_nettype none
module cep_isqrt (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [cep_pkg::RW-1:0] i_rad,
    output logic [cep_pkg::DW-1:0]      o_root,
    output logic                        o_done
);
    import cep_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [RW-1:0] r_rad;
    logic [49:0]   r_rem;
    logic [DW-1:0] r_root;

    logic [51:0] w_rem_sh;
    logic [51:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_rad[RW-1:RW-2]};
        w_diff   = w_rem_sh - {2'b00, r_root, 2'b01};
        w_ge     = !w_diff[51];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= 6'(DW);
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[49:0] : w_rem_sh[49:0];
            r_root <= {r_root[DW-2:0], w_ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== sv/cep_cordic.sv =====
`default_nettype none
module cep_cordic (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [49:0] i_dx,
    input  wire logic [49:0] i_dy,
    output logic [15:0]      o_heading,
    output logic             o_done
);
    import cep_pkg::*;

    t_cst               r_st, n_st;
    logic               r_done, n_done;
    logic               r_negx, n_negx;
    logic               r_negy, n_negy;
    logic [48:0]        r_ax, n_ax;
    logic [48:0]        r_ay, n_ay;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [19:0] r_acc, n_acc;
    logic [3:0]         r_i, n_i;
    logic [14:0]        r_a, n_a;
    logic [15:0]        r_head, n_head;

    logic [49:0]        w_ax50;
    logic [49:0]        w_ay50;
    logic [48:0]        w_m;
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;
    logic signed [19:0] w_ang;
    logic [18:0]        w_cl;
    logic [19:0]        w_rnd;
    logic [15:0]        w_a16;

    always_comb begin
        w_ax50 = i_dx[49] ? 50'd0 - i_dx : i_dx;
        w_ay50 = i_dy[49] ? 50'd0 - i_dy : i_dy;
        w_m    = (r_ax > r_ay) ? r_ax : r_ay;
        w_xs   = r_x >>> r_i;
        w_ys   = r_y >>> r_i;
        w_ang  = $signed(20'(cordic_angle(r_i)));
        if (r_acc[19]) begin
            w_cl = '0;
        end else if (r_acc > 20'sd262144) begin
            w_cl = 19'd262144;
        end else begin
            w_cl = r_acc[18:0];
        end
        w_rnd = {1'b0, w_cl} + 20'd8;
        w_a16 = {1'b0, r_a};

        n_st   = r_st;
        n_done = 1'b0;
        n_negx = r_negx;
        n_negy = r_negy;
        n_ax   = r_ax;
        n_ay   = r_ay;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_i    = r_i;
        n_a    = r_a;
        n_head = r_head;

        case (r_st)
            C_IDLE: begin
                if (i_start) begin
                    n_negx = i_dx[49];
                    n_negy = i_dy[49];
                    n_ax   = w_ax50[48:0];
                    n_ay   = w_ay50[48:0];
                    if (w_ay50 == '0) begin
                        n_a  = '0;
                        n_st = C_QUAD;
                    end else if (w_ax50 == '0) begin
                        n_a  = 15'd16384;
                        n_st = C_QUAD;
                    end else begin
                        n_st = C_NORM;
                    end
                end
            end
            C_NORM: begin
                if (|w_m[48:30]) begin
                    n_ax = {1'b0, r_ax[48:1]};
                    n_ay = {1'b0, r_ay[48:1]};
                end else if (!w_m[29]) begin
                    n_ax = {r_ax[47:0], 1'b0};
                    n_ay = {r_ay[47:0], 1'b0};
                end else begin
                    n_x   = $signed(r_ax[33:0]);
                    n_y   = $signed(r_ay[33:0]);
                    n_acc = '0;
                    n_i   = '0;
                    n_st  = C_ROT;
                end
            end
            C_ROT: begin
                if (!r_y[33]) begin
                    n_x   = r_x + w_ys;
                    n_y   = r_y - w_xs;
                    n_acc = r_acc + w_ang;
                end else begin
                    n_x   = r_x - w_ys;
                    n_y   = r_y + w_xs;
                    n_acc = r_acc - w_ang;
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'd15) begin
                    n_st = C_FIN;
                end
            end
            C_FIN: begin
                n_a  = w_rnd[18:4];
                n_st = C_QUAD;
            end
            C_QUAD: begin
                if (!r_negx && !r_negy) begin
                    n_head = w_a16;
                end else if (r_negx && !r_negy) begin
                    n_head = 16'h8000 - w_a16;
                end else if (r_negx) begin
                    n_head = 16'h8000 + w_a16;
                end else begin
                    n_head = 16'h0000 - w_a16;
                end
                n_done = 1'b1;
                n_st   = C_IDLE;
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_negx <= n_negx;
        r_negy <= n_negy;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_i    <= n_i;
        r_a    <= n_a;
        r_head <= n_head;
    end

    assign o_heading = r_head;
    assign o_done    = r_done;

endmodule
`default_nettype wire

// ===== sv/coulomb_euler_particle_step_top.sv =====
`default_nettype none
// Explicit Euler step of one charged particle in the field of a fixed charge at
// the origin. func=0 loads a particle (x from the start_x register, y and vx from
// the transaction, vy zero). func=1 advances one time step: |p|^2, an integer
// square root, r^3, the scaled numerator and two quotients for the velocity
// change, two multiplies by a reciprocal of 1e9 for the move, and a 16-step
// CORDIC for the heading. All wide products and quotients go through one
// bit-serial 192-bit multiply/divide unit (one add or subtract per cycle); the
// time a step takes varies with the CORDIC normalization shifts. The input is
// stalled while a transaction is in progress and while a finished one waits for
// the output register to free up; a finished transaction waits in the output
// register while the next one is taken.
module coulomb_euler_particle_step_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_func,
    input  wire logic signed [47:0] i_start_y,
    input  wire logic signed [47:0] i_start_vx,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [47:0]      o_pos_x,
    output logic signed [47:0]      o_pos_y,
    output logic signed [47:0]      o_vel_x,
    output logic signed [47:0]      o_vel_y,
    output logic [15:0]             o_heading,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);
    import cep_pkg::*;

    t_cfg          w_cfg;
    t_md_ctl       w_md_ctl;
    logic [BW-1:0] w_md_a, w_md_b, w_md_res;
    logic          w_md_done;
    logic          w_sq_start, w_sq_done;
    logic [DW-1:0] w_sq_root;
    logic          w_co_start, w_co_done;
    logic [15:0]   w_co_head;

    t_state        r_state, n_state;
    logic          r_issued, n_issued;
    logic          r_ovalid, n_ovalid;
    logic [47:0]   r_px, n_px, r_py, n_py, r_vx, n_vx, r_vy, n_vy;
    logic [BW-1:0] r_t, n_t, r_r3, n_r3, r_c, n_c;
    logic [DW-1:0] r_r, n_r;
    logic [49:0]   r_dx, n_dx, r_dy, n_dy;
    logic [15:0]   r_head, n_head;
    logic [47:0]   r_o_px, n_o_px, r_o_py, n_o_py, r_o_vx, n_o_vx, r_o_vy, n_o_vy;
    logic [15:0]   r_o_head, n_o_head;

    logic          w_md_use, w_use, w_udone;
    logic          w_sel_y;
    logic [47:0]   w_pc, w_v;
    logic [48:0]   w_m;
    logic [49:0]   w_dv, w_vsum, w_dp, w_psum, w_disp;
    logic [47:0]   w_pn;

    cep_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cep_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_md_ctl),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .o_res   (w_md_res),
        .o_done  (w_md_done)
    );

    cep_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (r_t[RW-1:0]),
        .o_root  (w_sq_root),
        .o_done  (w_sq_done)
    );

    cep_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_co_start),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .o_heading (w_co_head),
        .o_done    (w_co_done)
    );

    // velocity and position update shared by the x and y passes
    always_comb begin
        w_sel_y = (r_state == S_DY) || (r_state == S_DMY);
        w_pc    = w_sel_y ? r_py : r_px;
        w_v     = w_sel_y ? r_vy : r_vx;
        if (r_r == '0) begin
            w_m = '0;
        end else if (|w_md_res[BW-1:DW]) begin
            w_m = {1'b1, 48'd0};
        end else begin
            w_m = {1'b0, w_md_res[DW-1:0]};
        end
        w_dv   = (w_cfg.accel_coeff[31] ^ w_pc[47]) ? 50'd0 - {1'b0, w_m} : {1'b0, w_m};
        w_vsum = {{2{w_v[47]}}, w_v} + w_dv;
        w_dp   = w_v[47] ? 50'd0 - {10'd0, w_md_res[RECIP_SHIFT +: 40]}
                         : {10'd0, w_md_res[RECIP_SHIFT +: 40]};
        w_psum = {{2{w_pc[47]}}, w_pc} + w_dp;
        w_pn   = sat48(w_psum);
        w_disp = {{2{w_pn[47]}}, w_pn} - {{2{w_pc[47]}}, w_pc};
    end

    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_ovalid = r_ovalid && i_out_stall;
        n_px     = r_px;
        n_py     = r_py;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_t      = r_t;
        n_r3     = r_r3;
        n_c      = r_c;
        n_r      = r_r;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_head   = r_head;
        n_o_px   = r_o_px;
        n_o_py   = r_o_py;
        n_o_vx   = r_o_vx;
        n_o_vy   = r_o_vy;
        n_o_head = r_o_head;

        w_md_ctl.start = 1'b0;
        w_md_ctl.op    = MD_MUL;
        w_md_ctl.cnt   = MUL_CNT;
        w_md_a         = '0;
        w_md_b         = '0;
        w_md_use       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        n_px    = w_cfg.start_x;
                        n_py    = i_start_y;
                        n_vx    = i_start_vx;
                        n_vy    = '0;
                        n_head  = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SQX;
                    end
                end
            end
            S_SQX: begin
                w_md_use = 1'b1;
                w_md_a   = BW'(mag48(r_px));
                w_md_b   = BW'(mag48(r_px));
                if (w_md_done) begin
                    n_t     = w_md_res;
                    n_state = S_SQY;
                end
            end
            S_SQY: begin
                w_md_use = 1'b1;
                w_md_a   = BW'(mag48(r_py));
                w_md_b   = BW'(mag48(r_py));
                if (w_md_done) begin
                    n_t     = r_t + w_md_res;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sq_done) begin
                    n_r     = w_sq_root;
                    n_state = S_R2;
                end
            end
            S_R2: begin
                w_md_use = 1'b1;
                w_md_a   = BW'(r_r);
                w_md_b   = BW'(r_r);
                if (w_md_done) begin
                    n_t     = w_md_res;
                    n_state = S_R3;
                end
            end
            S_R3: begin
                w_md_use = 1'b1;
                w_md_a   = r_t;
                w_md_b   = BW'(r_r);
                if (w_md_done) begin
                    n_r3    = w_md_res;
                    n_state = S_C1;
                end
            end
            S_C1: begin
                w_md_use = 1'b1;
                w_md_a   = BW'(mag32(w_cfg.accel_coeff));
                w_md_b   = BW'(w_cfg.time_step);
                if (w_md_done) begin
                    n_c     = w_md_res;
                    n_state = S_C2;
                end
            end
            S_C2: begin
                w_md_use = 1'b1;
                w_md_a   = r_c;
                w_md_b   = GIGA;
                if (w_md_done) begin
                    n_c     = w_md_res;
                    n_state = S_C3;
                end
            end
            S_C3: begin
                w_md_use = 1'b1;
                w_md_a   = r_c;
                w_md_b   = GIGA;
                if (w_md_done) begin
                    n_c     = w_md_res;
                    n_state = S_C4;
                end
            end
            S_C4: begin
                w_md_use = 1'b1;
                w_md_a   = r_c;
                w_md_b   = KILO;
                if (w_md_done) begin
                    n_c     = w_md_res;
                    n_state = S_NX;
                end
            end
            S_NX: begin
                w_md_use = 1'b1;
                w_md_a   = r_c;
                w_md_b   = BW'(mag48(r_px));
                if (w_md_done) begin
                    n_t     = w_md_res;
                    n_state = S_DX;
                end
            end
            S_DX: begin
                w_md_use     = 1'b1;
                w_md_ctl.op  = MD_DIV;
                w_md_ctl.cnt = DIV_CNT;
                w_md_a       = r_t;
                w_md_b       = r_r3;
                if (w_md_done) begin
                    n_vx    = sat48(w_vsum);
                    n_state = S_NY;
                end
            end
            S_NY: begin
                w_md_use = 1'b1;
                w_md_a   = r_c;
                w_md_b   = BW'(mag48(r_py));
                if (w_md_done) begin
                    n_t     = w_md_res;
                    n_state = S_DY;
                end
            end
            S_DY: begin
                w_md_use     = 1'b1;
                w_md_ctl.op  = MD_DIV;
                w_md_ctl.cnt = DIV_CNT;
                w_md_a       = r_t;
                w_md_b       = r_r3;
                if (w_md_done) begin
                    n_vy    = sat48(w_vsum);
                    n_state = S_MX;
                end
            end
            S_MX: begin
                w_md_use = 1'b1;
                w_md_a   = BW'(mag48(r_vx));
                w_md_b   = BW'(w_cfg.time_step);
                if (w_md_done) begin
                    n_t     = w_md_res;
                    n_state = S_DMX;
                end
            end
            S_DMX: begin
                w_md_use     = 1'b1;
                w_md_ctl.cnt = MOVE_CNT;
                w_md_a       = RECIP_GIGA;
                w_md_b       = r_t;
                if (w_md_done) begin
                    n_px    = w_pn;
                    n_dx    = w_disp;
                    n_state = S_MY;
                end
            end
            S_MY: begin
                w_md_use = 1'b1;
                w_md_a   = BW'(mag48(r_vy));
                w_md_b   = BW'(w_cfg.time_step);
                if (w_md_done) begin
                    n_t     = w_md_res;
                    n_state = S_DMY;
                end
            end
            S_DMY: begin
                w_md_use     = 1'b1;
                w_md_ctl.cnt = MOVE_CNT;
                w_md_a       = RECIP_GIGA;
                w_md_b       = r_t;
                if (w_md_done) begin
                    n_py    = w_pn;
                    n_dy    = w_disp;
                    n_state = S_CORD;
                end
            end
            S_CORD: begin
                if (w_co_done) begin
                    n_head  = w_co_head;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_o_px   = r_px;
                    n_o_py   = r_py;
                    n_o_vx   = r_vx;
                    n_o_vy   = r_vy;
                    n_o_head = r_head;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        w_use          = w_md_use || (r_state == S_SQRT) || (r_state == S_CORD);
        w_udone        = w_md_done || w_sq_done || w_co_done;
        w_md_ctl.start = w_md_use && !r_issued;
        w_sq_start     = (r_state == S_SQRT) && !r_issued;
        w_co_start     = (r_state == S_CORD) && !r_issued;
        n_issued       = w_use && !w_udone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_px     <= '0;
            r_py     <= '0;
            r_vx     <= '0;
            r_vy     <= '0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ovalid <= n_ovalid;
            r_px     <= n_px;
            r_py     <= n_py;
            r_vx     <= n_vx;
            r_vy     <= n_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_r3     <= n_r3;
        r_c      <= n_c;
        r_r      <= n_r;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_head   <= n_head;
        r_o_px   <= n_o_px;
        r_o_py   <= n_o_py;
        r_o_vx   <= n_o_vx;
        r_o_vy   <= n_o_vy;
        r_o_head <= n_o_head;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_pos_x     = r_o_px;
    assign o_pos_y     = r_o_py;
    assign o_vel_x     = r_o_vx;
    assign o_vel_y     = r_o_vy;
    assign o_heading   = r_o_head;

endmodule
`default_nettype wire

// ===== tb/sv/particle_step_checker.sv =====
`default_nettype none
module particle_step_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic               i_func,
    input  wire logic signed [47:0] i_start_y,
    input  wire logic signed [47:0] i_start_vx,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [47:0] i_pos_x,
    input  wire logic signed [47:0] i_pos_y,
    input  wire logic signed [47:0] i_vel_x,
    input  wire logic signed [47:0] i_vel_y,
    input  wire logic [15:0]        i_heading,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [4:0]         i_paddr,
    input  wire logic [63:0]        i_pwdata,
    output int                      o_errors,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cep_pkg::*;

    typedef struct packed {
        logic [47:0] px;
        logic [47:0] py;
        logic [47:0] vx;
        logic [47:0] vy;
        logic [15:0] hd;
    } t_particle_out;

    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -MAX48 - 1;
    localparam longint unsigned BILLION = 64'd1000000000;

    t_cfg          cfg;
    longint        px, py, vx, vy;
    t_particle_out expected_q[$];
    int            errors;

    assign o_errors  = errors;
    assign o_pending = expected_q.size();

    function automatic longint clamp48(input longint v);
        return v > MAX48 ? MAX48 : (v < MIN48 ? MIN48 : v);
    endfunction

    function automatic longint unsigned absval(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint coulomb_dv(input longint pc, input logic [191:0] r3);
        logic [191:0]   num, quo;
        longint unsigned m;
        if (pc == 0 || cfg.accel_coeff == 0 || r3 == 0) return 0;
        num = 192'(absval(longint'(cfg.accel_coeff)));
        num = num * 192'(cfg.time_step);
        num = num * 192'(absval(pc));
        num = num * 192'(BILLION) * 192'(BILLION) * 192'(1000);
        quo = num / r3;
        m = (quo >= (192'd1 << 48)) ? (64'd1 << 48) : quo[63:0];
        return ((cfg.accel_coeff < 0) != (pc < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint euler_move(input longint v);
        longint unsigned a, d;
        a = absval(v);
        d = (a / BILLION) * cfg.time_step + ((a % BILLION) * cfg.time_step) / BILLION;
        return v < 0 ? -longint'(d) : longint'(d);
    endfunction

    function automatic logic [15:0] move_heading(input longint dx, input longint dy);
        longint unsigned ax, ay, m, a;
        longint x, y, xs, ys, acc;
        ax = absval(dx);
        ay = absval(dy);
        acc = 0;
        if (ax == 0 && ay == 0) return 16'd0;
        if (ay == 0) begin
            a = 0;
        end else if (ax == 0) begin
            a = 16384;
        end else begin
            m = ax > ay ? ax : ay;
            while (m >= (64'd1 << 30)) begin
                m >>= 1; ax >>= 1; ay >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                m <<= 1; ax <<= 1; ay <<= 1;
            end
            x = ax;
            y = ay;
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys; y -= xs; acc += longint'(cordic_angle(4'(i)));
                end else begin
                    x -= ys; y += xs; acc -= longint'(cordic_angle(4'(i)));
                end
            end
            if (acc < 0) acc = 0;
            if (acc > 262144) acc = 262144;
            a = (longint'(acc) + 8) >> 4;
        end
        if (dx >= 0 && dy >= 0) return 16'(a);
        if (dx < 0 && dy >= 0) return 16'(32768 - a);
        if (dx < 0) return 16'(32768 + a);
        return 16'(65536 - a);
    endfunction

    function automatic t_particle_out advance_particle(input logic fn, input longint sy,
                                                       input longint svx);
        t_particle_out r;
        logic [191:0]  r2, c, r3;
        longint unsigned root;
        longint        nx, ny;
        r.hd = 16'd0;
        if (fn == FUNC_LOAD) begin
            px = cfg.start_x;
            py = sy;
            vx = svx;
            vy = 0;
        end else begin
            r2 = 192'(absval(px)) * 192'(absval(px)) + 192'(absval(py)) * 192'(absval(py));
            root = 0;
            for (int b = 47; b >= 0; b--) begin
                c = 192'(root | (64'd1 << b));
                if (c * c <= r2) root = c[63:0];
            end
            r3 = 192'(root) * 192'(root) * 192'(root);
            vx = clamp48(vx + coulomb_dv(px, r3));
            vy = clamp48(vy + coulomb_dv(py, r3));
            nx = clamp48(px + euler_move(vx));
            ny = clamp48(py + euler_move(vy));
            r.hd = move_heading(nx - px, ny - py);
            px = nx;
            py = ny;
        end
        r.px = px[47:0];
        r.py = py[47:0];
        r.vx = vx[47:0];
        r.vy = vy[47:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d actual %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_particle_out w;
        if (!i_rst_n) begin
            cfg <= '{accel_coeff: ACCEL_RST, time_step: STEP_RST, start_x: START_X_RST};
            px = 0; py = 0; vx = 0; vy = 0;
            expected_q.delete();
            errors = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_ACCEL:   cfg.accel_coeff <= i_pwdata[31:0];
                    REG_STEP:    cfg.time_step   <= i_pwdata[19:0];
                    REG_START_X: cfg.start_x     <= i_pwdata[47:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no expected result");
                    errors++;
                end else begin
                    w = expected_q.pop_front();
                    check_field("pos_x", w.px, i_pos_x);
                    check_field("pos_y", w.py, i_pos_y);
                    check_field("vel_x", w.vx, i_vel_x);
                    check_field("vel_y", w.vy, i_vel_y);
                    check_field("heading", 48'(w.hd), 48'(i_heading));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.insert(expected_q.size(),
                                  advance_particle(i_func, i_start_y, i_start_vx));
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cep_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic               clk, rst_n;
    logic               in_valid, in_stall, func;
    logic signed [47:0] start_y, start_vx;
    logic               out_valid, out_stall;
    logic signed [47:0] pos_x, pos_y, vel_x, vel_y;
    logic [15:0]        heading;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [63:0]        pwdata, prdata;
    int                 errors, pending;
    logic               quiet;
    int                 sent, idle_cnt;

    coulomb_euler_particle_step_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_start_y(start_y), .i_start_vx(start_vx),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_vel_x(vel_x), .o_vel_y(vel_y),
        .o_heading(heading),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    particle_step_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_start_y(start_y), .i_start_vx(start_vx),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_heading(heading),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    // watchdog: cycles with no transaction anywhere
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    function automatic logic [47:0] rand48();
        logic [63:0] raw;
        int          k;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return {1'b0, {47{1'b1}}};
            1: return {1'b1, 47'd0};
            2: return raw[47:0];
            default: begin
                k = $urandom_range(47);
                raw = raw & ((64'd1 << k) - 1);
                return $urandom_range(1) ? 48'd0 - raw[47:0] : raw[47:0];
            end
        endcase
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic send_item(input logic fn, input logic [47:0] y, input logic [47:0] v);
        in_valid <= 1'b1;
        func     <= fn;
        start_y  <= y;
        start_vx <= v;
        do @(posedge clk); while (in_stall);
        sent++;
        if (!quiet && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [19:0] ts;
        rst_n = 1'b0;
        in_valid <= 1'b0; func <= 1'b0; start_y <= '0; start_vx <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        quiet = 1'b0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration, default particle
        send_item(FUNC_LOAD, 48'd0, 48'd1000000000);
        send_item(FUNC_STEP, '0, '0);
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();
        // extremes of every register and field
        reg_write(REG_ACCEL, 64'h7FFF_FFFF);
        reg_write(REG_STEP, 64'hF_FFFF);
        reg_write(REG_START_X, {16'd0, 1'b1, 47'd0});
        send_item(FUNC_LOAD, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}});
        send_item(FUNC_STEP, '0, '0);
        send_item(FUNC_STEP, '0, '0);
        send_item(FUNC_LOAD, {1'b1, 47'd0}, {1'b1, 47'd0});
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();
        // particle at origin, then zero time step, then zero charge product
        reg_write(REG_START_X, 64'd0);
        send_item(FUNC_LOAD, 48'd0, 48'd0);
        send_item(FUNC_STEP, '0, '0);
        send_item(FUNC_LOAD, 48'd0, 48'd5000000000);
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();
        reg_write(REG_STEP, 64'd0);
        send_item(FUNC_LOAD, 48'd777, 48'd123456789012);
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();
        reg_write(REG_STEP, 64'd1);
        reg_write(REG_ACCEL, 64'd0);
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();
        // huge acceleration close in, then saturated position
        reg_write(REG_ACCEL, 64'hFFFF_FFFF_8000_0000);
        reg_write(REG_START_X, 64'd1);
        send_item(FUNC_LOAD, 48'd1, 48'd0);
        send_item(FUNC_STEP, '0, '0);
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();
        reg_write(REG_STEP, 64'hF_FFFF);
        reg_write(REG_ACCEL, 64'd3183);
        reg_write(REG_START_X, {16'd0, 1'b0, {47{1'b1}}});
        send_item(FUNC_LOAD, {1'b1, 47'd0}, {1'b0, {47{1'b1}}});
        send_item(FUNC_STEP, '0, '0);
        send_item(FUNC_STEP, '0, '0);
        idle_input(); drain();

        for (int ph = 0; ph < 6; ph++) begin
            quiet = (ph == 2);
            reg_write(REG_ACCEL, {32'd0, 32'(rand48())});
            case ($urandom_range(3))
                0: ts = 20'($urandom_range(1, 100000));
                1: ts = 20'(1 << $urandom_range(19));
                2: ts = 20'hF_FFFF;
                default: ts = 20'($urandom);
            endcase
            reg_write(REG_STEP, {44'd0, ts});
            reg_write(REG_START_X, {16'd0, rand48()});
            while (sent < 30 + 250 * (ph + 1)) begin
                if ($urandom_range(9) == 0) begin
                    send_item(1'($urandom), rand48(), rand48());
                end else begin
                    send_item(FUNC_LOAD, rand48(), rand48());
                    repeat ($urandom_range(8)) send_item(FUNC_STEP, rand48(), rand48());
                end
            end
            idle_input(); drain();
        end

        quiet = 1'b0;
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
